// ===== src/pal_pkg.sv =====
`timescale 1ns / 1ps
// Package with constants, codes and transaction types for the positional array list.
package pal_pkg;

	localparam int CAPACITY    = 8;
	localparam int VALUE_WIDTH = 16;
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int POS_W       = 4;
	localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_FIND   = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_FULL      = 3'd1,
		STS_EMPTY     = 3'd2,
		STS_BAD_POS   = 3'd3,
		STS_NOT_FOUND = 3'd4
	} status_t;

	typedef struct packed {
		op_t              mode;
		logic [15:0]      value;
		logic [POS_W-1:0] position;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] data_out;
		logic [3:0]  found_position;
		logic [3:0]  count;
	} rsp_t;

endpackage

// ===== src/positional_array_list_unit.sv =====
`timescale 1ns / 1ps
// Positional array list: insert, delete, find and read over entries held in one memory.
// A rejected request skips the memory walk; other requests walk the list, and the memory
// streams one entry per cycle during the walk. A new request is taken only after the previous one
// has finished its walk and its response has been loaded into the output register.
// A new request is taken while the previous response still waits in the output register.
// Reset clears the entry count and control state; the entry memory itself is not cleared.
module positional_array_list_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  pal_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output pal_pkg::rsp_t   rsp
);
	import pal_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RUN  = 4'b0010,
		S_INS  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] mem [CAPACITY];
	logic [VALUE_WIDTH-1:0] rdata_q;

	logic [CNT_W-1:0]       count_q;
	op_t                    op_q;
	status_t                status_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [VALUE_WIDTH-1:0] data_q;
	logic [CNT_W-1:0]       found_q;
	logic [IDX_W-1:0]       pos_m1_q;
	logic [IDX_W-1:0]       rd_idx_q;
	logic [CNT_W-1:0]       rd_left_q;
	logic                   pend_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic [CMP_W-1:0]       pos_x;
	logic [CMP_W-1:0]       cnt_x;
	logic                   accept;
	status_t                chk_status;
	logic                   chk_run;
	logic [CNT_W-1:0]       chk_left;
	logic [IDX_W-1:0]       chk_idx;

	logic                   rd_go;
	logic                   match_now;
	logic                   run_end;
	logic                   we;
	logic [IDX_W-1:0]       wa;
	logic [VALUE_WIDTH-1:0] wd;
	logic                   load_rsp;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign pos_x = CMP_W'(req.position);
	assign cnt_x = CMP_W'(count_q);

	always_comb begin
		chk_status = STS_OK;
		chk_run    = 1'b0;
		chk_left   = '0;
		chk_idx    = '0;
		priority if (req.mode == OP_INSERT) begin
			if (count_q == CNT_W'(CAPACITY)) begin
				chk_status = STS_FULL;
			end else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
				chk_status = STS_BAD_POS;
			end else begin
				chk_run  = 1'b1;
				chk_left = CNT_W'(cnt_x - pos_x + CMP_W'(1));
				chk_idx  = IDX_W'(cnt_x - CMP_W'(1));
			end
		end else if (count_q == '0) begin
			chk_status = STS_EMPTY;
		end else if (req.mode == OP_FIND) begin
			chk_status = STS_NOT_FOUND;
			chk_run    = 1'b1;
			chk_left   = count_q;
			chk_idx    = '0;
		end else if (pos_x == '0 || pos_x > cnt_x) begin
			chk_status = STS_BAD_POS;
		end else begin
			chk_run  = 1'b1;
			chk_left = (req.mode == OP_READ) ? CNT_W'(1)
			                                 : CNT_W'(cnt_x - pos_x + CMP_W'(1));
			chk_idx  = IDX_W'(pos_x - CMP_W'(1));
		end
	end

	assign match_now = (state_q == S_RUN) && (op_q == OP_FIND) && pend_s1 && (rdata_q == val_q);
	assign rd_go     = (state_q == S_RUN) && (rd_left_q != '0) && !match_now;
	assign run_end   = ((rd_left_q == '0) && !pend_s1) || match_now;
	assign load_rsp  = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		we = 1'b0;
		wa = idx_s1;
		wd = rdata_q;
		if (state_q == S_RUN && pend_s1) begin
			if (op_q == OP_INSERT) begin
				we = 1'b1;
				wa = idx_s1 + IDX_W'(1);
			end else if (op_q == OP_DELETE && idx_s1 != pos_m1_q) begin
				we = 1'b1;
				wa = idx_s1 - IDX_W'(1);
			end
		end else if (state_q == S_INS) begin
			we = 1'b1;
			wa = pos_m1_q;
			wd = val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && !load_rsp) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= chk_run ? S_RUN : S_DONE;
					end
				end
				S_RUN: begin
					pend_s1 <= rd_go;
					if (run_end) begin
						if (op_q == OP_INSERT) begin
							state_q <= S_INS;
						end else begin
							if (op_q == OP_DELETE) begin
								count_q <= count_q - CNT_W'(1);
							end
							state_q <= S_DONE;
						end
					end
				end
				S_INS: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_rsp) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= req.mode;
			status_q  <= chk_status;
			val_q     <= VALUE_WIDTH'(req.value);
			data_q    <= '0;
			found_q   <= '0;
			pos_m1_q  <= IDX_W'(pos_x - CMP_W'(1));
			rd_idx_q  <= chk_idx;
			rd_left_q <= chk_left;
		end else begin
			if (rd_go) begin
				rd_left_q <= rd_left_q - CNT_W'(1);
				rd_idx_q  <= (op_q == OP_INSERT) ? rd_idx_q - IDX_W'(1)
				                                 : rd_idx_q + IDX_W'(1);
			end
			if (match_now) begin
				status_q <= STS_OK;
				found_q  <= CNT_W'(idx_s1) + CNT_W'(1);
			end
			if (state_q == S_RUN && pend_s1 && idx_s1 == pos_m1_q &&
			    (op_q == OP_DELETE || op_q == OP_READ)) begin
				data_q <= rdata_q;
			end
		end
		idx_s1 <= rd_idx_q;
		if (load_rsp) begin
			rsp_q.status         <= status_q;
			rsp_q.data_out       <= 16'(data_q);
			rsp_q.found_position <= 4'(found_q);
			rsp_q.count          <= 4'(count_q);
		end
	end

endmodule

// ===== sim/pal_list_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts list responses from accepted requests and compares each response.
module pal_list_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  pal_pkg::req_t  req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  pal_pkg::rsp_t  rsp,
	output int             mismatches,
	output int             pending
);
	import pal_pkg::*;

	logic [VALUE_WIDTH-1:0] list_mem [CAPACITY];
	int                     list_len;
	rsp_t                   expected_rsps [$];

	function automatic rsp_t apply_list_op(req_t r);
		rsp_t o;
		int   k;
		int   p;
		o.status         = STS_OK;
		o.data_out       = '0;
		o.found_position = '0;
		p = r.position;
		if (r.mode == OP_INSERT) begin
			if (list_len >= CAPACITY)
				o.status = STS_FULL;
			else if (p == 0 || p > list_len + 1)
				o.status = STS_BAD_POS;
			else begin
				for (k = list_len; k >= p; k--)
					list_mem[k] = list_mem[k-1];
				list_mem[p-1] = r.value[VALUE_WIDTH-1:0];
				list_len++;
			end
		end else if (list_len == 0) begin
			o.status = STS_EMPTY;
		end else if (r.mode == OP_FIND) begin
			o.status = STS_NOT_FOUND;
			for (k = 0; k < list_len; k++) begin
				if (o.status == STS_NOT_FOUND && list_mem[k] == r.value[VALUE_WIDTH-1:0]) begin
					o.status         = STS_OK;
					o.found_position = 4'(k + 1);
				end
			end
		end else if (p == 0 || p > list_len) begin
			o.status = STS_BAD_POS;
		end else begin
			o.data_out = 16'(list_mem[p-1]);
			if (r.mode == OP_DELETE) begin
				for (k = p; k < list_len; k++)
					list_mem[k-1] = list_mem[k];
				list_len--;
			end
		end
		o.count = 4'(list_len);
		return o;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches = mismatches + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			list_len   = 0;
			mismatches = 0;
			expected_rsps.delete();
			pending <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$error("response with no request outstanding");
					mismatches = mismatches + 1;
				end else begin
					want = expected_rsps.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("data_out", want.data_out, rsp.data_out);
					check_field("found_position", want.found_position, rsp.found_position);
					check_field("count", want.count, rsp.count);
				end
			end
			if (req_valid && req_ready)
				expected_rsps.push_back(apply_list_op(req));
			pending <= expected_rsps.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top that drives list requests and response back-pressure and reports the verdict.
module tb_top;
	import pal_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 800;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	int   mismatches;
	int   pending;
	int   cycle_count;
	bit   rsp_hold_req;
	int   burst_left;

	logic [15:0] value_pool [8];

	positional_array_list_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	pal_list_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic req_t make_req(op_t m, logic [15:0] v, logic [3:0] p);
		req_t r;
		r.mode     = m;
		r.value    = v;
		r.position = p;
		return r;
	endfunction

	function automatic req_t random_req(int phase);
		int   r;
		op_t  m;
		logic [15:0] v;
		logic [3:0]  p;
		r = $urandom_range(99);
		case (phase)
			0: m = (r < 60) ? OP_INSERT : (r < 75) ? OP_FIND : (r < 90) ? OP_READ : OP_DELETE;
			1: m = (r < 60) ? OP_DELETE : (r < 70) ? OP_INSERT : (r < 85) ? OP_FIND : OP_READ;
			default: m = op_t'(r % 4);
		endcase
		r = $urandom_range(99);
		v = (r < 60) ? value_pool[$urandom_range(7)] : 16'($urandom);
		r = $urandom_range(99);
		if (r < 50)
			p = 4'($urandom_range(2, 1));
		else if (r < 80)
			p = 4'($urandom_range(CAPACITY + 1, 1));
		else
			p = 4'($urandom_range(15));
		return make_req(m, v, p);
	endfunction

	task automatic send_req(req_t r);
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	task automatic rest_sender();
		int r;
		int gap;
		gap = 0;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			r = $urandom_range(99);
			if (r < 55)
				gap = 0;
			else if (r < 85)
				gap = $urandom_range(3, 1);
			else if (r < 95)
				gap = $urandom_range(10, 4);
			else if (r < 98)
				gap = $urandom_range(60, 20);
			else
				burst_left = $urandom_range(80, 30);
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_list_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin : rsp_side
		int r;
		int hold_left;
		int free_run;
		bit hold_done;
		hold_left = 0;
		free_run  = 0;
		hold_done = 1'b0;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (rsp_hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 400;
				rsp_ready <= 1'b0;
			end else if (free_run > 0) begin
				free_run--;
				rsp_ready <= 1'b1;
			end else begin
				r = $urandom_range(99);
				if (r < 60) begin
					rsp_ready <= 1'b1;
				end else if (r < 90) begin
					rsp_ready <= 1'b0;
				end else if (r < 96) begin
					rsp_ready <= 1'b0;
					hold_left = $urandom_range(40, 5);
				end else begin
					rsp_ready <= 1'b1;
					free_run = $urandom_range(60, 20);
				end
			end
		end
	end

	initial begin : stimulus
		req_t opening [$];
		int   phase;
		int   phase_left;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		rsp_hold_req = 1'b0;
		burst_left   = 0;
		value_pool[0] = 16'h0000;
		value_pool[1] = 16'hFFFF;
		for (int i = 2; i < 8; i++)
			value_pool[i] = 16'($urandom);

		// Fill the list from empty to full, hit every error case, then delete three entries.
		opening.push_back(make_req(OP_DELETE, 16'h0000, 4'd1));
		opening.push_back(make_req(OP_FIND,   16'h0000, 4'd0));
		opening.push_back(make_req(OP_READ,   16'h0000, 4'd1));
		opening.push_back(make_req(OP_INSERT, 16'h1111, 4'd0));
		opening.push_back(make_req(OP_INSERT, 16'h2222, 4'd2));
		opening.push_back(make_req(OP_INSERT, 16'h0000, 4'd1));
		opening.push_back(make_req(OP_INSERT, 16'hFFFF, 4'd2));
		opening.push_back(make_req(OP_INSERT, 16'h1234, 4'd1));
		opening.push_back(make_req(OP_INSERT, 16'hFFFF, 4'd3));
		opening.push_back(make_req(OP_INSERT, 16'hA5A5, 4'd5));
		opening.push_back(make_req(OP_INSERT, 16'h5A5A, 4'd2));
		opening.push_back(make_req(OP_INSERT, 16'h3333, 4'd15));
		opening.push_back(make_req(OP_INSERT, 16'h8000, 4'd7));
		opening.push_back(make_req(OP_INSERT, 16'h0001, 4'd4));
		opening.push_back(make_req(OP_INSERT, 16'h7FFF, 4'd1));
		opening.push_back(make_req(OP_FIND,   16'hFFFF, 4'd15));
		opening.push_back(make_req(OP_FIND,   16'h4321, 4'd3));
		opening.push_back(make_req(OP_READ,   16'hFFFF, 4'd0));
		opening.push_back(make_req(OP_READ,   16'h0000, 4'd8));
		opening.push_back(make_req(OP_READ,   16'h0000, 4'd9));
		opening.push_back(make_req(OP_READ,   16'h0000, 4'd15));
		opening.push_back(make_req(OP_DELETE, 16'h0000, 4'd0));
		opening.push_back(make_req(OP_DELETE, 16'h0000, 4'd8));
		opening.push_back(make_req(OP_DELETE, 16'hFFFF, 4'd1));
		opening.push_back(make_req(OP_DELETE, 16'h0000, 4'd3));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i]) begin
			send_req(opening[i]);
			rest_sender();
		end
		wait_list_idle();

		phase      = 0;
		phase_left = $urandom_range(40, 10);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// The receiver stalls for a long stretch while requests keep coming.
			if (n == 300)
				rsp_hold_req = 1'b1;
			if (n == 550)
				wait_list_idle();
			if (phase_left == 0) begin
				phase      = (phase + 1) % 3;
				phase_left = $urandom_range(40, 10);
			end
			phase_left--;
			send_req(random_req(phase));
			rest_sender();
		end

		wait_list_idle();
		repeat (CAPACITY + 8) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
